>>> rtl/core/sctfp_pkg.sv
package sctfp_pkg;

  localparam int unsigned NumFields = 12;
  localparam int unsigned IdWidth   = 4;

  typedef enum logic [2:0] {
    PhIdle  = 3'd0,
    PhBegin = 3'd1,
    PhName  = 3'd2,
    PhValue = 3'd3,
    PhCheck = 3'd4,
    PhHex   = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    NpWs     = 3'd0,
    NpSign   = 3'd1,
    NpDigits = 3'd2,
    NpDone   = 3'd3,
    NpFrozen = 3'd4
  } num_phase_e;

  // Field ids in result order.
  localparam logic [IdWidth-1:0] FidV    = 4'd0;
  localparam logic [IdWidth-1:0] FidI    = 4'd1;
  localparam logic [IdWidth-1:0] FidVpv  = 4'd2;
  localparam logic [IdWidth-1:0] FidPpv  = 4'd3;
  localparam logic [IdWidth-1:0] FidIl   = 4'd4;
  localparam logic [IdWidth-1:0] FidLoad = 4'd5;
  localparam logic [IdWidth-1:0] FidCs   = 4'd6;
  localparam logic [IdWidth-1:0] FidMppt = 4'd7;
  localparam logic [IdWidth-1:0] FidErr  = 4'd8;
  localparam logic [IdWidth-1:0] FidH20  = 4'd9;
  localparam logic [IdWidth-1:0] FidH22  = 4'd10;
  localparam logic [IdWidth-1:0] FidHsds = 4'd11;
  localparam logic [IdWidth-1:0] FidLast = 4'd11;

  // Frame-end request from the parser to the result emitter.
  typedef struct packed {
    logic valid;
    logic ok;
  } frame_end_t;

endpackage

>>> rtl/core/sctfp_emit.sv
module sctfp_emit (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  sctfp_pkg::frame_end_t                    end_i,
  input  logic [sctfp_pkg::NumFields-1:0][31:0]    fields_i,
  output logic                                     busy_o,
  output logic                                     valid_o,
  input  logic                                     stall_i,
  output logic                                     frame_ok_o,
  output logic [sctfp_pkg::IdWidth-1:0]            field_id_o,
  output logic signed [31:0]                       field_value_o,
  output logic                                     last_of_frame_o
);
  import sctfp_pkg::*;

  logic                          valid_q;
  logic                          ok_q;
  logic [IdWidth-1:0]            id_q;
  logic [NumFields-1:0][31:0]    snap_q;

  logic last;
  assign last = !ok_q || (id_q == FidLast);

  // Step through a snapshot of the committed fields, one result per handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ok_q    <= 1'b0;
      id_q    <= '0;
    end else if (end_i.valid) begin
      valid_q <= 1'b1;
      ok_q    <= end_i.ok;
      id_q    <= '0;
    end else if (valid_q && !stall_i) begin
      if (last) begin
        valid_q <= 1'b0;
      end else begin
        id_q <= id_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (end_i.valid) begin
      snap_q <= fields_i;
    end
  end

  assign busy_o          = valid_q;
  assign valid_o         = valid_q;
  assign frame_ok_o      = ok_q;
  assign field_id_o      = ok_q ? id_q : '0;
  assign field_value_o   = ok_q ? signed'(snap_q[id_q]) : '0;
  assign last_of_frame_o = last;

  a_id_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> id_q <= FidLast) else $error("field id out of range");
  a_bad_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !ok_q) |-> id_q == '0) else $error("invalid frame past first result");
  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_i.valid |-> !valid_q) else $error("frame end while emitting");

endmodule

>>> rtl/core/solar_charger_text_frame_parser.sv
// Channel | Direction | Handshake             | Payload
// rx      | in        | rx_valid_i/rx_stall_o | rx_byte_i
// res     | out       | res_valid_o/res_stall_i | frame_ok_o, field_id_o, field_value_o,
//         |           |                       | last_of_frame_o
// One byte per cycle: each byte updates the parser registers in the cycle it is taken.
// A good checksum with no overlong record starts twelve result transactions, a bad
// one a single one; the result register then hands out one per unstalled cycle.
// While results of a frame are still pending, new bytes are stalled (rx_stall_o).
// Reset clears parser state (not label bytes), pending and committed fields at once.
module solar_charger_text_frame_parser #(
  parameter int unsigned LABEL_MAX = 16,
  parameter int unsigned VALUE_MAX = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rx_valid_i,
  output logic               rx_stall_o,
  input  logic [7:0]         rx_byte_i,
  output logic               res_valid_o,
  input  logic               res_stall_i,
  output logic               frame_ok_o,
  output logic [3:0]         field_id_o,
  output logic signed [31:0] field_value_o,
  output logic               last_of_frame_o
);
  import sctfp_pkg::*;

  localparam int unsigned LenW  = $clog2(LABEL_MAX + 1);
  localparam int unsigned VLenW = $clog2(VALUE_MAX + 1);
  localparam int unsigned IdxW  = $clog2(LABEL_MAX);

  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChColon = 8'h3A;

  phase_e                     phase_q, phase_d;
  logic [7:0]                 sum_q, sum_d;
  logic [LABEL_MAX-1:0][7:0]  lbl_q;
  logic [LenW-1:0]            llen_q, llen_d;
  logic [VLenW-1:0]           vlen_q, vlen_d;
  logic                       long_q, long_d;
  logic [32:0]                acc_q, acc_d;
  num_phase_e                 np_q, np_d;
  logic [1:0]                 on_q, on_d;
  logic [NumFields-1:0][31:0] pend_q, pend_d;
  logic [NumFields-1:0][31:0] good_q, good_d;
  logic                       lastgood_q, lastgood_d;
  logic                       lbl_we;
  logic [IdxW-1:0]            lbl_idx;
  frame_end_t                 fend;
  logic                       emit_busy;
  logic                       acc_byte;

  assign rx_stall_o = emit_busy;
  assign acc_byte   = rx_valid_i && !rx_stall_o;

  // Effective label: characters up to the first zero byte.
  logic [LABEL_MAX-1:0][7:0]  eff;
  logic [LenW-1:0]            elen;
  always_comb begin
    logic stop;
    stop = 1'b0;
    elen = '0;
    for (int k = 0; k < LABEL_MAX; k++) begin
      eff[k] = 8'h00;
      if (!stop && (LenW'(k) < llen_q) && lbl_q[k] != 8'h00) begin
        eff[k] = lbl_q[k];
        elen   = LenW'(k + 1);
      end else begin
        stop = 1'b1;
      end
    end
  end

  function automatic logic lbl_eq(input logic [LABEL_MAX-1:0][7:0] l,
                                  input logic [LenW-1:0] n,
                                  input logic [63:0] s, input int unsigned len);
    logic r;
    r = (n == LenW'(len));
    for (int k = 0; k < 8; k++) begin
      if (k < len && l[k] != s[8*(len-1-k) +: 8]) r = 1'b0;
    end
    return r;
  endfunction

  // Value conversion result.
  logic [31:0] mag, vint, vint10;
  always_comb begin
    mag    = acc_q[31:0];
    vint   = acc_q[32] ? (32'd0 - mag) : ((mag > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag);
    vint10 = {vint[28:0], 3'b000} + {vint[30:0], 1'b0};
  end

  // Next accumulator for one digit; clamp magnitude at 2^31.
  logic [36:0] dig_mag;
  logic [32:0] acc_dig;
  always_comb begin
    dig_mag = {5'd0, acc_q[31:0]} * 37'd10 + {33'd0, rx_byte_i[3:0]};
    acc_dig = {acc_q[32], (dig_mag > 37'h0_8000_0000) ? 32'h8000_0000 : dig_mag[31:0]};
  end

  logic is_digit, is_ws;
  assign is_digit = (rx_byte_i >= 8'h30) && (rx_byte_i <= 8'h39);
  assign is_ws    = (rx_byte_i == 8'h20) || (rx_byte_i == 8'h09) ||
                    (rx_byte_i == 8'h0B) || (rx_byte_i == 8'h0C);

  always_comb begin
    phase_e ph;
    logic   ok;
    phase_d    = phase_q;
    sum_d      = sum_q;
    llen_d     = llen_q;
    vlen_d     = vlen_q;
    long_d     = long_q;
    acc_d      = acc_q;
    np_d       = np_q;
    on_d       = on_q;
    pend_d     = pend_q;
    good_d     = good_q;
    lastgood_d = lastgood_q;
    lbl_we     = 1'b0;
    lbl_idx    = '0;
    fend       = '0;
    ok         = 1'b0;
    ph         = phase_q;
    if (acc_byte) begin
      if (rx_byte_i == ChColon && phase_q != PhCheck) ph = PhHex;
      phase_d = ph;
      if (ph != PhHex) sum_d = sum_q + rx_byte_i;
      case (ph)
        PhIdle: begin
          if (rx_byte_i == ChLf) phase_d = PhBegin;
        end
        PhBegin: begin
          lbl_we  = 1'b1;
          lbl_idx = '0;
          llen_d  = LenW'(1);
          phase_d = PhName;
        end
        PhName: begin
          if (rx_byte_i == ChTab) begin
            if (lbl_eq(eff, elen, 64'h436865636B73756D, 8)) begin
              phase_d = PhCheck;
            end else begin
              vlen_d  = '0;
              acc_d   = '0;
              np_d    = NpWs;
              on_d    = 2'd0;
              phase_d = PhValue;
            end
          end else if (llen_q < LenW'(LABEL_MAX - 1)) begin
            lbl_we  = 1'b1;
            lbl_idx = llen_q[IdxW-1:0];
            llen_d  = llen_q + 1'b1;
          end else begin
            long_d = 1'b1;
          end
        end
        PhValue: begin
          if (rx_byte_i == ChLf) begin
            // Store the finished record into its pending field.
            if (!long_q) begin
              if (lbl_eq(eff, elen, 64'h56, 1))           pend_d[FidV]    = vint;
              else if (lbl_eq(eff, elen, 64'h49, 1))      pend_d[FidI]    = vint;
              else if (lbl_eq(eff, elen, 64'h565056, 3))  pend_d[FidVpv]  = vint;
              else if (lbl_eq(eff, elen, 64'h505056, 3))  pend_d[FidPpv]  = vint;
              else if (lbl_eq(eff, elen, 64'h494C, 2))    pend_d[FidIl]   = vint;
              else if (lbl_eq(eff, elen, 64'h4C4F4144, 4))
                pend_d[FidLoad] = {31'd0, on_q == 2'd2};
              else if (lbl_eq(eff, elen, 64'h4353, 2))    pend_d[FidCs]   = vint;
              else if (lbl_eq(eff, elen, 64'h4D505054, 4)) pend_d[FidMppt] = vint;
              else if (lbl_eq(eff, elen, 64'h455252, 3))  pend_d[FidErr]  = vint;
              else if (lbl_eq(eff, elen, 64'h483230, 3))  pend_d[FidH20]  = vint10;
              else if (lbl_eq(eff, elen, 64'h483232, 3))  pend_d[FidH22]  = vint10;
              else if (lbl_eq(eff, elen, 64'h48534453, 4) ||
                       lbl_eq(eff, elen, 64'h48736473, 4)) pend_d[FidHsds] = vint;
            end
            phase_d = PhBegin;
          end else if (rx_byte_i == ChCr) begin
            // skip
          end else if (vlen_q < VLenW'(VALUE_MAX - 1)) begin
            vlen_d = vlen_q + 1'b1;
            if (np_q != NpFrozen) begin
              if (rx_byte_i == 8'h00) begin
                np_d = NpFrozen;
              end else begin
                if (on_q == 2'd0)      on_d = (rx_byte_i == 8'h4F) ? 2'd1 : 2'd3;
                else if (on_q == 2'd1) on_d = (rx_byte_i == 8'h4E) ? 2'd2 : 2'd3;
                else                   on_d = 2'd3;
                if (np_q == NpWs) begin
                  if (is_ws) begin
                    np_d = NpWs;
                  end else if (rx_byte_i == 8'h2B) begin
                    np_d = NpSign;
                  end else if (rx_byte_i == 8'h2D) begin
                    acc_d[32] = 1'b1;
                    np_d      = NpSign;
                  end else if (is_digit) begin
                    acc_d = acc_dig;
                    np_d  = NpDigits;
                  end else begin
                    np_d = NpDone;
                  end
                end else if (np_q == NpSign || np_q == NpDigits) begin
                  if (is_digit) begin
                    acc_d = acc_dig;
                    np_d  = NpDigits;
                  end else begin
                    np_d = NpDone;
                  end
                end
              end
            end
          end else begin
            long_d = 1'b1;
          end
        end
        PhCheck: begin
          ok         = (sum_d == 8'h00) && !long_q;
          lastgood_d = ok;
          if (ok) good_d = pend_q;
          fend.valid = 1'b1;
          fend.ok    = ok;
          pend_d     = '0;
          sum_d      = '0;
          long_d     = 1'b0;
          phase_d    = PhIdle;
        end
        default: begin
          if (rx_byte_i == ChLf) begin
            pend_d  = '0;
            sum_d   = '0;
            long_d  = 1'b0;
            phase_d = PhIdle;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      sum_q      <= '0;
      llen_q     <= '0;
      vlen_q     <= '0;
      long_q     <= 1'b0;
      acc_q      <= '0;
      np_q       <= NpWs;
      on_q       <= 2'd0;
      pend_q     <= '0;
      good_q     <= '0;
      lastgood_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      sum_q      <= sum_d;
      llen_q     <= llen_d;
      vlen_q     <= vlen_d;
      long_q     <= long_d;
      acc_q      <= acc_d;
      np_q       <= np_d;
      on_q       <= on_d;
      pend_q     <= pend_d;
      good_q     <= good_d;
      lastgood_q <= lastgood_d;
    end
  end

  // Label bytes: no reset, only read below the fill length.
  always_ff @(posedge clk_i) begin
    if (lbl_we) lbl_q[lbl_idx] <= rx_byte_i;
  end

  sctfp_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .end_i          (fend),
    .fields_i       (good_d),
    .busy_o         (emit_busy),
    .valid_o        (res_valid_o),
    .stall_i        (res_stall_i),
    .frame_ok_o     (frame_ok_o),
    .field_id_o     (field_id_o),
    .field_value_o  (field_value_o),
    .last_of_frame_o(last_of_frame_o)
  );

  a_llen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    llen_q <= LenW'(LABEL_MAX - 1)) else $error("label length overrun");
  a_vlen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vlen_q <= VLenW'(VALUE_MAX - 1)) else $error("value length overrun");
  a_end_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fend.valid |=> (phase_q == PhIdle && sum_q == 8'h00)) else $error("frame end not cleared");

endmodule
